FILE: rtl/ins_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ins_pkg
// shared types for the insertion sorter: element type and cell control
// ----------------------------------------------------------------------------
package ins_pkg;

  localparam int ELEM_W = 32;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the incoming element
    logic shl;  // shift the chain one place towards cell 0
  } cell_ctl_t;

endpackage : ins_pkg
`default_nettype wire

FILE: rtl/ins_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ins_cell
// one compare-and-shift cell of the sorting chain
// ----------------------------------------------------------------------------
module ins_cell #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  wire logic               clk,
  input  wire ins_pkg::cell_ctl_t ctl,
  input  wire ins_pkg::elem_t     elem,
  input  wire logic [CNT_W-1:0]   held_count,
  input  wire ins_pkg::elem_t     left_val,
  input  wire logic               left_gt,
  input  wire ins_pkg::elem_t     right_val,
  output ins_pkg::elem_t          val,
  output logic                    gt
);
  import ins_pkg::*;

  logic occ;
  logic at_tail;

  assign occ     = CNT_W'(IDX) < held_count;
  assign at_tail = CNT_W'(IDX) == held_count;
  // held value is strictly greater than the incoming one
  assign gt      = occ && (elem < val);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_gt) begin
        val <= left_val;
      end else if (gt || at_tail) begin
        val <= elem;
      end
    end else if (ctl.shl) begin
      val <= right_val;
    end
  end

endmodule : ins_cell
`default_nettype wire

FILE: rtl/insertion_sorter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sorter_top
// stable ascending sorter for sets of signed 32-bit elements
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one element per item; the item
// with last set closes the set. Each accepted item is placed in a row of
// MAX_ELEMENTS compare-and-shift cells, all cells deciding in parallel, so
// a set is taken at one item per cycle. Equal values keep their arrival
// order. Items beyond MAX_ELEMENTS are dropped and the whole run is then
// flagged with overflow.
// After the last item the chain drains through cell 0 into an output
// register, one result per cycle while the receiver does not stall. The
// last item enters the chain and the drain state, then the output register
// takes cell 0. in_stall is high while the chain drains; receiver stalls
// prolong the drain. The last result, marked by final_res, may wait in the
// output register while items of the next set are already accepted.
// When the receiver raises out_stall the output register holds its item and
// the chain stops shifting. Reset (rst, synchronous) empties the store,
// clears the overflow flag and drops any pending result; no clearing pass.
// ----------------------------------------------------------------------------
module insertion_sorter_top #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ins_pkg::elem_t       element,
  input  wire logic                 last,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ins_pkg::elem_t            sorted_value,
  output logic                      final_res,
  output logic                      overflow
);
  import ins_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] held_count;   // number of occupied cells
  logic             dropped_flag; // an element of this set was lost

  logic      accept;
  logic      room;
  logic      load;   // move cell 0 into the output register
  cell_ctl_t ctl;

  elem_t cell_val [MAX_ELEMENTS];
  logic  cell_gt  [MAX_ELEMENTS];

  // input is held off only while the set drains
  assign in_stall = (state == ST_DRAIN);
  assign accept   = in_valid && !in_stall;
  assign room     = held_count < CNT_W'(MAX_ELEMENTS);
  assign load     = (state == ST_DRAIN) && (!out_valid || !out_stall);

  assign ctl.ins = accept && room;
  assign ctl.shl = load;

  // the sorting chain: each cell sees its left neighbour when inserting and
  // its right neighbour when draining
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    ins_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .elem       (element),
      .held_count (held_count),
      .left_val   ((i == 0) ? cell_val[0] : cell_val[(i == 0) ? 0 : i - 1]),
      .left_gt    ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
      .right_val  (cell_val[(i == MAX_ELEMENTS - 1) ? i : i + 1]),
      .val        (cell_val[i]),
      .gt         (cell_gt[i])
    );
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      held_count   <= '0;
      dropped_flag <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        ST_FILL: begin
          if (accept) begin
            if (room) begin
              held_count <= held_count + CNT_W'(1);
            end else begin
              dropped_flag <= 1'b1;
            end
            if (last) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (load) begin
            held_count <= held_count - CNT_W'(1);
            if (held_count == CNT_W'(1)) begin
              state        <= ST_FILL;
              dropped_flag <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase

      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    // output payload, no reset needed
    if (load) begin
      sorted_value <= cell_val[0];
      final_res    <= (held_count == CNT_W'(1));
      overflow     <= dropped_flag;
    end
  end

  // the store never holds more than its capacity
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(MAX_ELEMENTS))
    else $error("held count beyond capacity");

  // a set that drains always has a value left to emit
  a_drain_nonempty : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (held_count != '0))
    else $error("draining an empty store");

  // emitting the final value leaves an empty, clean store
  a_drain_done : assert property (@(posedge clk) disable iff (rst)
    (load && (held_count == CNT_W'(1))) |=>
      ((state == ST_FILL) && (held_count == '0) && !dropped_flag && final_res))
    else $error("store not cleared after final result");

  // an element offered to a full store marks the set as overflowed
  a_drop_flag : assert property (@(posedge clk) disable iff (rst)
    (accept && !room) |=> dropped_flag)
    else $error("dropped element not flagged");

endmodule : insertion_sorter_top
`default_nettype wire

FILE: verif/insertion_sorter_top_tb.sv
// ----------------------------------------------------------------------------
// insertion_sorter_top_tb
// self-checking bench for the stable ascending insertion sorter
// ----------------------------------------------------------------------------
// Elements are fed one item at a time through the valid/stall input channel.
// A behavioural sorter inside the bench tracks the store, the held count and
// the dropped flag, and queues the sorted run that each closing item should
// produce. Every result taken from the output channel is compared, field by
// field, against the oldest queued entry. A short table of hand-picked sets
// comes first, then random sets, including one that fills the store and
// runs past its capacity. Both sides idle at random, apart from one stretch
// with no idling.
// ----------------------------------------------------------------------------
module insertion_sorter_top_tb;

  import ins_pkg::*;

  localparam int    CAPACITY    = 64;
  localparam int    CYCLE_LIMIT = 200000;
  localparam elem_t ELEM_MIN    = 32'sh8000_0000;
  localparam elem_t ELEM_MAX    = 32'sh7fff_ffff;

  // one sorted value as it should leave the block
  typedef struct {
    elem_t value;
    logic  fin;
    logic  ovf;
  } sorted_item_t;

  // directed row: element, last flag, and an optional hand-written result
  // (single-element sets only, so the result is the element itself)
  typedef struct packed {
    elem_t elem;
    logic  lst;
    logic  typed;
    elem_t t_val;
    logic  t_ovf;
  } stim_row_t;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  elem_t element   = '0;
  logic  last      = 1'b0;
  logic  out_stall = 1'b0;
  logic  in_stall;
  logic  out_valid;
  elem_t sorted_value;
  logic  final_res;
  logic  overflow;

  // bench copy of the sorter state
  elem_t sort_store [CAPACITY];
  int    held_vals = 0;
  logic  was_dropped = 1'b0;

  // sorted values still to come out of the block, oldest first
  sorted_item_t sorted_out_q [$];
  sorted_item_t head_item;

  int  bad_results = 0;
  int  sent_items  = 0;
  int  cycle_count = 0;
  bit  steady      = 1'b0;  // set: neither side idles

  stim_row_t stim_rows [24] = '{
    // single-element sets straight after reset: result is the element
    '{ELEM_MIN,      1'b1, 1'b1, ELEM_MIN, 1'b0},
    '{ELEM_MAX,      1'b1, 1'b1, ELEM_MAX, 1'b0},
    '{32'sd0,        1'b1, 1'b1, 32'sd0,   1'b0},
    '{-32'sd1,       1'b1, 1'b1, -32'sd1,  1'b0},
    // mixed set with repeated values and both extremes
    '{32'sd7,        1'b0, 1'b0, 32'sd0,   1'b0},
    '{-32'sd3,       1'b0, 1'b0, 32'sd0,   1'b0},
    '{32'sd7,        1'b0, 1'b0, 32'sd0,   1'b0},
    '{ELEM_MAX,      1'b0, 1'b0, 32'sd0,   1'b0},
    '{ELEM_MIN,      1'b0, 1'b0, 32'sd0,   1'b0},
    '{32'sd7,        1'b0, 1'b0, 32'sd0,   1'b0},
    '{32'sd0,        1'b1, 1'b0, 32'sd0,   1'b0},
    // descending arrival, every element moves to the front
    '{32'sd100,      1'b0, 1'b0, 32'sd0,   1'b0},
    '{32'sd50,       1'b0, 1'b0, 32'sd0,   1'b0},
    '{-32'sd50,      1'b0, 1'b0, 32'sd0,   1'b0},
    '{-32'sd100,     1'b1, 1'b0, 32'sd0,   1'b0},
    // ascending arrival, every element stays at the back
    '{-32'sd100,     1'b0, 1'b0, 32'sd0,   1'b0},
    '{-32'sd50,      1'b0, 1'b0, 32'sd0,   1'b0},
    '{32'sd50,       1'b0, 1'b0, 32'sd0,   1'b0},
    '{32'sd100,      1'b1, 1'b0, 32'sd0,   1'b0},
    // all equal
    '{32'sd42,       1'b0, 1'b0, 32'sd0,   1'b0},
    '{32'sd42,       1'b0, 1'b0, 32'sd0,   1'b0},
    '{32'sd42,       1'b1, 1'b0, 32'sd0,   1'b0},
    // extremes in reverse order
    '{ELEM_MAX,      1'b0, 1'b0, 32'sd0,   1'b0},
    '{ELEM_MIN,      1'b1, 1'b0, 32'sd0,   1'b0}
  };

  insertion_sorter_top #(
    .MAX_ELEMENTS (CAPACITY)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element      (element),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflow     (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stable insertion: a new value goes after every held value <= it;
  // a closing item queues the whole held run and empties the store
  function automatic void sort_in(input elem_t value, input logic closes);
    int           pos;
    sorted_item_t res;
    if (held_vals < CAPACITY) begin
      pos = held_vals;
      while (pos > 0 && value < sort_store[pos-1]) begin
        sort_store[pos] = sort_store[pos-1];
        pos--;
      end
      sort_store[pos] = value;
      held_vals++;
    end else begin
      was_dropped = 1'b1;  // store full, element lost
    end
    if (closes) begin
      for (int k = 0; k < held_vals; k++) begin
        res.value = sort_store[k];
        res.fin   = (k == held_vals - 1);
        res.ovf   = was_dropped;
        sorted_out_q.push_back(res);
      end
      held_vals   = 0;
      was_dropped = 1'b0;
    end
  endfunction

  // random element: full range, a narrow band for duplicates, or an extreme
  function automatic elem_t rand_elem();
    case ($urandom_range(0, 3))
      0:       rand_elem = elem_t'($urandom_range(0, 8)) - 32'sd4;
      1:       rand_elem = $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
      default: rand_elem = elem_t'($urandom());
    endcase
  endfunction

  // present one item, hold it until accepted, then update the bench state
  task automatic push_item(input elem_t value, input logic closes, input logic typed,
                           input elem_t t_val, input logic t_ovf);
    int           base;
    sorted_item_t res;
    if (!steady) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    element  <= value;
    last     <= closes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    base = sorted_out_q.size();
    sort_in(value, closes);
    if (typed) begin
      // the hand-written result replaces what the bench sorter queued
      while (sorted_out_q.size() > base) void'(sorted_out_q.pop_back());
      res.value = t_val;
      res.fin   = 1'b1;
      res.ovf   = t_ovf;
      sorted_out_q.push_back(res);
    end
  endtask

  task automatic random_set(input int n);
    for (int i = 0; i < n; i++) push_item(rand_elem(), i == n - 1, 1'b0, '0, 1'b0);
  endtask

  // sender goes quiet until every queued result has come out
  task automatic await_drain();
    in_valid <= 1'b0;
    while (sorted_out_q.size() != 0) @(posedge clk);
  endtask

  // receiver: check each accepted result, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sorted_out_q.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("unexpected result: value %0d final %b overflow %b",
                     sorted_value, final_res, overflow);
        end else begin
          head_item = sorted_out_q.pop_front();
          if (sorted_value !== head_item.value || final_res !== head_item.fin ||
              overflow !== head_item.ovf) begin
            bad_results++;
            if (bad_results <= 10)
              $display("mismatch: expected %0d/%b/%b, got %0d/%b/%b",
                       head_item.value, head_item.fin, head_item.ovf,
                       sorted_value, final_res, overflow);
          end
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 33);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // hand-picked sets
    foreach (stim_rows[i])
      push_item(stim_rows[i].elem, stim_rows[i].lst, stim_rows[i].typed,
                stim_rows[i].t_val, stim_rows[i].t_ovf);

    // hold off until the directed runs are fully out
    await_drain();

    // short random sets
    while (sent_items < 30) random_set($urandom_range(1, 8));

    // store filled, then extra elements dropped, closing item dropped as
    // well; no idling here
    await_drain();
    steady = 1'b1;
    random_set(CAPACITY + $urandom_range(1, 3));
    await_drain();
    steady = 1'b0;

    // overflow flag must be clear again for the following sets
    repeat (4) random_set($urandom_range(1, 6));

    await_drain();
    repeat (20) @(posedge clk);
    if (bad_results == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ins_pkg.sv
rtl/ins_cell.sv
rtl/insertion_sorter_top.sv
verif/insertion_sorter_top_tb.sv
